// ===== hw/rtl/wsr_pkg.sv =====
// Shared types, constants and helpers for the wildcard signature scanner.
`default_nettype none

package wsr_pkg;

    localparam int MAX_PATTERN_DEF = 16;
    localparam int ADDR_WIDTH_DEF  = 48;
    localparam int PAT_LIMIT       = 16;
    localparam int LEN_W           = 5;
    localparam int POS_W           = 32;
    localparam int DISP_BYTES      = 4;
    localparam int DISP_W          = 32;
    localparam int BASE_W          = 48;
    localparam int ADJ_W           = 32;
    localparam int SUM_W           = 64;
    localparam int CFG_W           = 64;
    localparam int CFG_ADDR_W      = 3;
    localparam int NCAND           = 5;
    localparam int QUEUE_DEPTH     = 4;

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_PATTERN_LOW    = 3'd0,
        REG_PATTERN_HIGH   = 3'd1,
        REG_PATTERN_LENGTH = 3'd2,
        REG_REGION_BASE    = 3'd3,
        REG_POINTER_ADJUST = 3'd4
    } wsr_reg_t;

    typedef struct packed {
        logic [CFG_W-1:0]  pattern_low;
        logic [CFG_W-1:0]  pattern_high;
        logic [LEN_W-1:0]  pattern_length;
        logic [BASE_W-1:0] region_base;
        logic [ADJ_W-1:0]  pointer_adjust;
    } wsr_cfg_t;

    typedef struct packed {
        logic              found;
        logic [POS_W-1:0]  pos;
        logic [LEN_W-1:0]  k;
        logic [DISP_W-1:0] disp;
    } wsr_job_t;

    function automatic logic [7:0] pat_byte(input logic [CFG_W-1:0] lo,
                                            input logic [CFG_W-1:0] hi,
                                            input logic [3:0] idx);
        logic [CFG_W-1:0] w;
        w = idx[3] ? hi : lo;
        return w[{idx[2:0], 3'b000} +: 8];
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/wsr_queue.sv =====
// Small register FIFO between the scan front and the pointer back end.
`default_nettype none

module wsr_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire logic [WIDTH-1:0] push_data,
    output logic                  full,
    input  wire logic             pop,
    output logic [WIDTH-1:0]      pop_data,
    output logic                  empty
);
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg, count_next;
    logic             do_push, do_pop;

    assign full     = (count_reg == CW'(DEPTH));
    assign empty    = (count_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign pop_data = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/wsr_front.sv =====
// Scan front: byte window, match search over candidate starts, job generation.
`default_nettype none

module wsr_front #(
    parameter int MAX_PATTERN = wsr_pkg::MAX_PATTERN_DEF
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire wsr_pkg::wsr_cfg_t cfg,
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    input  wire logic [7:0]        data_byte,
    input  wire logic              last_byte,
    output logic                   push,
    output wsr_pkg::wsr_job_t      job,
    input  wire logic              q_ready
);
    import wsr_pkg::*;

    localparam int WIN = MAX_PATTERN + DISP_BYTES;
    localparam int IW  = $clog2(WIN);
    localparam int FW  = $clog2(WIN + 1);

    logic [7:0]       win_reg [WIN];
    logic [7:0]       win_next [WIN];
    logic [FW-1:0]    fill_reg, fill_next;
    logic [POS_W-1:0] seen_reg, seen_next;
    logic             last_reg, last_next;
    logic             pend_reg, pend_next;
    logic             done_reg, done_next;

    logic             accept, eval_fire;
    logic [LEN_W-1:0] len, k, need;
    logic [7:0]       pat [MAX_PATTERN];
    logic             hit;
    logic [POS_W-1:0] hit_pos;
    logic [DISP_W-1:0] hit_disp;

    assign s_tready  = !pend_reg || q_ready;
    assign accept    = s_tvalid && s_tready;
    assign eval_fire = pend_reg && q_ready;

    // pattern length, first wildcard index and bytes needed per start
    always_comb
    begin
        for (int i = 0; i < MAX_PATTERN; i++)
        begin
            pat[i] = pat_byte(cfg.pattern_low, cfg.pattern_high, 4'(i));
        end
        if (cfg.pattern_length == '0)
        begin
            len = LEN_W'(1);
        end
        else if (cfg.pattern_length > LEN_W'(MAX_PATTERN))
        begin
            len = LEN_W'(MAX_PATTERN);
        end
        else
        begin
            len = cfg.pattern_length;
        end
        k = len;
        for (int i = MAX_PATTERN - 1; i >= 0; i--)
        begin
            if (LEN_W'(i) < len && pat[i] == 8'h00)
            begin
                k = LEN_W'(i);
            end
        end
        need = (k + LEN_W'(DISP_BYTES) > len) ? k + LEN_W'(DISP_BYTES) : len;
    end

    // candidate starts: the regular one, then shorter tails at region end
    always_comb
    begin
        int         o;
        int         idx;
        logic       ok;
        logic [7:0] b;
        logic [DISP_W-1:0] d;
        hit      = 1'b0;
        hit_pos  = '0;
        hit_disp = '0;
        for (int j = NCAND - 1; j >= 0; j--)
        begin
            o  = int'(need) - 1 - j;
            ok = (j == 0 || last_reg) && o >= int'(len) - 1 && o >= 0
                 && o < int'(fill_reg);
            for (int i = 0; i < MAX_PATTERN; i++)
            begin
                idx = o - i;
                b   = (idx >= 0 && idx < WIN) ? win_reg[IW'(idx)] : 8'h00;
                if (LEN_W'(i) < len && pat[i] != 8'h00 && b != pat[i])
                begin
                    ok = 1'b0;
                end
            end
            d = '0;
            for (int i = 0; i < DISP_BYTES; i++)
            begin
                idx = o - int'(k) - i;
                if (idx >= 0 && idx < WIN)
                begin
                    d[8*i +: 8] = win_reg[IW'(idx)];
                end
            end
            if (ok)
            begin
                hit      = 1'b1;
                hit_pos  = seen_reg - POS_W'(o + 1);
                hit_disp = d;
            end
        end
    end

    assign push      = eval_fire && !done_reg && (hit || last_reg);
    assign job.found = hit;
    assign job.pos   = hit ? hit_pos : '0;
    assign job.k     = k;
    assign job.disp  = hit_disp;

    always_comb
    begin
        win_next  = win_reg;
        fill_next = fill_reg;
        seen_next = seen_reg;
        last_next = last_reg;
        pend_next = pend_reg;
        done_next = done_reg;
        if (eval_fire)
        begin
            pend_next = 1'b0;
            done_next = last_reg ? 1'b0 : (done_reg || hit);
        end
        if (accept)
        begin
            for (int i = WIN - 1; i > 0; i--)
            begin
                win_next[i] = win_reg[i-1];
            end
            win_next[0] = data_byte;
            if (last_reg)
            begin
                fill_next = FW'(1);
                seen_next = POS_W'(1);
            end
            else
            begin
                fill_next = (fill_reg == FW'(WIN)) ? fill_reg : fill_reg + 1'b1;
                seen_next = seen_reg + 1'b1;
            end
            last_next = last_byte;
            pend_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg <= '0;
            seen_reg <= '0;
            last_reg <= 1'b0;
            pend_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            fill_reg <= fill_next;
            seen_reg <= seen_next;
            last_reg <= last_next;
            pend_reg <= pend_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        win_reg <= win_next;
    end

    a_push_has_room: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> q_ready)
        else $error("job pushed into full queue");

    a_accept_then_pending: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> pend_reg)
        else $error("accepted item not pending evaluation");

    a_last_clears_done: assert property (@(posedge clk) disable iff (!rst_n)
        eval_fire && last_reg |=> !done_reg)
        else $error("match flag survived end of region");

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= FW'(WIN))
        else $error("window fill count out of range");

endmodule

`default_nettype wire

// ===== hw/rtl/wsr_back.sv =====
// Pointer back end: two-stage address sum and output register.
`default_nettype none

module wsr_back #(
    parameter int ADDR_WIDTH = wsr_pkg::ADDR_WIDTH_DEF
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire wsr_pkg::wsr_cfg_t      cfg,
    input  wire logic                   job_valid,
    input  wire wsr_pkg::wsr_job_t      job,
    output logic                        job_pop,
    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    output logic                        found,
    output logic [wsr_pkg::POS_W-1:0]   match_position,
    output logic [ADDR_WIDTH-1:0]       resolved_pointer
);
    import wsr_pkg::*;

    logic             s1_valid_reg, s1_valid_next;
    logic             s1_found_reg;
    logic [POS_W-1:0] s1_pos_reg;
    logic [SUM_W-1:0] s1_a_reg, s1_b_reg;
    logic             out_valid_reg, out_valid_next;
    logic             out_found_reg;
    logic [POS_W-1:0] out_pos_reg;
    logic [ADDR_WIDTH-1:0] out_ptr_reg;
    logic [SUM_W-1:0] sum;
    logic             s1_load, out_load;

    assign out_load = s1_valid_reg && (!out_valid_reg || m_tready);
    assign s1_load  = job_valid && (!s1_valid_reg || out_load);
    assign job_pop  = s1_load;
    assign sum      = s1_a_reg + s1_b_reg;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (s1_load)
        begin
            s1_valid_next = 1'b1;
        end
        else if (out_load)
        begin
            s1_valid_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_load)
        begin
            s1_found_reg <= job.found;
            s1_pos_reg   <= job.pos;
            s1_a_reg     <= SUM_W'(cfg.region_base) + SUM_W'(job.pos)
                            + SUM_W'(job.k) + SUM_W'(DISP_BYTES);
            s1_b_reg     <= SUM_W'($signed(job.disp)) + SUM_W'($signed(cfg.pointer_adjust));
        end
        if (out_load)
        begin
            out_found_reg <= s1_found_reg;
            out_pos_reg   <= s1_pos_reg;
            out_ptr_reg   <= s1_found_reg ? sum[ADDR_WIDTH-1:0] : '0;
        end
    end

    assign m_tvalid         = out_valid_reg;
    assign found            = out_found_reg;
    assign match_position   = out_pos_reg;
    assign resolved_pointer = out_ptr_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/wildcard_signature_scan_rel32_core.sv =====
// Wildcard byte-pattern scanner with rel32 pointer resolution, top level.
//
// Region bytes enter on the s_ stream, one item per byte, tlast on the
// region's final byte. Each region yields at most one result on the m_
// stream: tuser=1 with the first match start and its resolved pointer, or
// tuser=0 (position and pointer zero) at the last byte if nothing matched.
// Pattern, length, base and adjust are written through the cfg port; the user
// must write them only while the block is idle, the block does not enforce it.
// Throughput: one byte per cycle while the job queue has room. A result
// reaches m_tvalid after the byte that completes it has passed through
// match evaluation into the job queue, the adder stage and the output register.
// A stalled receiver fills the output register, the adder stage and the
// 4-entry job queue; the input side keeps taking bytes until the queue is
// full and one byte waits for evaluation, then drops s_tready.
// Reset clears the scan state and loads the register defaults (length 1);
// no clearing pass is needed, the block takes bytes as soon as reset is released.
`default_nettype none

module wildcard_signature_scan_rel32_core #(
    parameter int MAX_PATTERN = wsr_pkg::MAX_PATTERN_DEF,
    parameter int ADDR_WIDTH  = wsr_pkg::ADDR_WIDTH_DEF
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_we,
    input  wire logic [wsr_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  wire logic [wsr_pkg::CFG_W-1:0]      cfg_wdata,
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    input  wire logic [7:0]                     s_tdata,  // data_byte
    input  wire logic                           s_tlast,  // last_byte
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    // match_position, resolved_pointer, zero fill
    output logic [((wsr_pkg::POS_W + ADDR_WIDTH + 7) / 8) * 8 - 1:0] m_tdata,
    output logic                                m_tuser   // found
);
    import wsr_pkg::*;

    localparam int OUT_W = ((POS_W + ADDR_WIDTH + 7) / 8) * 8;
    localparam int JOB_W = $bits(wsr_job_t);

    wsr_cfg_t              cfg_reg;
    logic                  q_push, q_full, q_pop, q_empty;
    wsr_job_t              push_job, pop_job;
    logic [JOB_W-1:0]      pop_bits;
    logic [POS_W-1:0]      pos;
    logic [ADDR_WIDTH-1:0] ptr;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.pattern_low    <= '0;
            cfg_reg.pattern_high   <= '0;
            cfg_reg.pattern_length <= LEN_W'(1);
            cfg_reg.region_base    <= '0;
            cfg_reg.pointer_adjust <= '0;
        end
        else if (cfg_we)
        begin
            unique case (wsr_reg_t'(cfg_addr))
                REG_PATTERN_LOW:    cfg_reg.pattern_low    <= cfg_wdata;
                REG_PATTERN_HIGH:   cfg_reg.pattern_high   <= cfg_wdata;
                REG_PATTERN_LENGTH: cfg_reg.pattern_length <= cfg_wdata[LEN_W-1:0];
                REG_REGION_BASE:    cfg_reg.region_base    <= cfg_wdata[BASE_W-1:0];
                REG_POINTER_ADJUST: cfg_reg.pointer_adjust <= cfg_wdata[ADJ_W-1:0];
                default:            ;
            endcase
        end
    end

    wsr_front #(
        .MAX_PATTERN(MAX_PATTERN)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .data_byte (s_tdata),
        .last_byte (s_tlast),
        .push      (q_push),
        .job       (push_job),
        .q_ready   (!q_full)
    );

    wsr_queue #(
        .WIDTH(JOB_W),
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (push_job),
        .full      (q_full),
        .pop       (q_pop),
        .pop_data  (pop_bits),
        .empty     (q_empty)
    );

    assign pop_job = wsr_job_t'(pop_bits);

    wsr_back #(
        .ADDR_WIDTH(ADDR_WIDTH)
    ) u_back (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg              (cfg_reg),
        .job_valid        (!q_empty),
        .job              (pop_job),
        .job_pop          (q_pop),
        .m_tvalid         (m_tvalid),
        .m_tready         (m_tready),
        .found            (m_tuser),
        .match_position   (pos),
        .resolved_pointer (ptr)
    );

    assign m_tdata = OUT_W'({ptr, pos});

endmodule

`default_nettype wire

// ===== sim/wildcard_signature_scan_rel32_core_tb.sv =====
// Self-checking testbench for the wildcard signature scanner with rel32 pointer resolution.
`default_nettype none

module wildcard_signature_scan_rel32_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import wsr_pkg::*;

    localparam int CLK_PERIOD    = 10;
    localparam int OUT_W         = ((POS_W + BASE_W + 7) / 8) * 8;
    localparam int WIN_DEPTH     = PAT_LIMIT + DISP_BYTES;
    localparam int SETTLE_CYCLES = 10;
    localparam int LONG_HOLD     = 400;
    localparam int RANDOM_ITEMS  = 600;
    localparam int RUN_LIMIT_NS  = 2_000_000;

    typedef struct packed {
        logic              found;
        logic [POS_W-1:0]  pos;
        logic [BASE_W-1:0] ptr;
    } scan_result_t;

    typedef enum {ROW_ITEM, ROW_WRITE} row_kind_e;

    typedef struct {
        row_kind_e             kind;
        logic [CFG_ADDR_W-1:0] addr;
        logic [CFG_W-1:0]      value;
        logic [7:0]            data;
        bit                    last;
        bit                    typed;
        scan_result_t          want;
    } plan_row_t;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  cfg_we    = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr  = '0;
    logic [CFG_W-1:0]      cfg_wdata = '0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [7:0]            s_tdata   = '0;  // data_byte
    logic                  s_tlast   = 1'b0;  // last_byte
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [OUT_W-1:0]      m_tdata;  // match_position, resolved_pointer
    logic                  m_tuser;  // found

    // scanner mirror
    logic [CFG_W-1:0]  m_pat_lo  = '0;
    logic [CFG_W-1:0]  m_pat_hi  = '0;
    logic [LEN_W-1:0]  m_pat_len = 5'd1;
    logic [BASE_W-1:0] m_base    = '0;
    logic [ADJ_W-1:0]  m_adj     = '0;
    logic [7:0]        scan_win [0:WIN_DEPTH-1];
    logic [POS_W-1:0]  scan_seen;
    bit                scan_done;
    int                scan_fill;

    scan_result_t pending_results[$];
    plan_row_t    plan[$];
    int           errors      = 0;
    int           burst_left  = 0;
    int           live_items  = 0;
    bit           hold_req    = 1'b0;
    bit           hold_done   = 1'b0;

    wildcard_signature_scan_rel32_core DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    function automatic void scan_clear();
        for (int i = 0; i < WIN_DEPTH; i++)
            scan_win[i] = 8'h00;
        scan_seen = '0;
        scan_done = 1'b0;
        scan_fill = 0;
    endfunction

    function automatic logic [7:0] pattern_at(int i);
        logic [CFG_W-1:0] w;
        w = (i < 8) ? m_pat_lo : m_pat_hi;
        return w[(i % 8) * 8 +: 8];
    endfunction

    function automatic logic [7:0] window_at(int o, int i);
        int idx;
        idx = o - i;
        if (idx < 0 || idx >= WIN_DEPTH)
            return 8'h00;
        return scan_win[idx];
    endfunction

    function automatic int pattern_span();
        if (m_pat_len == 0)
            return 1;
        if (m_pat_len > PAT_LIMIT)
            return PAT_LIMIT;
        return int'(m_pat_len);
    endfunction

    function automatic bit try_start_at(int o, int len, int k, logic [POS_W-1:0] back,
                                        output scan_result_t r);
        logic [DISP_W-1:0] disp;
        logic [SUM_W-1:0]  sum;
        r = '0;
        for (int i = 0; i < len; i++)
            if (pattern_at(i) != 8'h00 && window_at(o, i) != pattern_at(i))
                return 1'b0;
        disp = '0;
        for (int i = 0; i < DISP_BYTES; i++)
            disp[i * 8 +: 8] = window_at(o, k + i);
        r.found = 1'b1;
        r.pos   = scan_seen - back;
        sum = SUM_W'(m_base) + SUM_W'(r.pos) + SUM_W'(k) + SUM_W'(DISP_BYTES)
            + {{(SUM_W - DISP_W){disp[DISP_W-1]}}, disp}
            + {{(SUM_W - ADJ_W){m_adj[ADJ_W-1]}}, m_adj};
        r.ptr = sum[BASE_W-1:0];
        return 1'b1;
    endfunction

    function automatic bit scan_byte(logic [7:0] d, bit last, output scan_result_t r);
        int len;
        int k;
        int need;
        bit hit;
        hit = 1'b0;
        r   = '0;
        for (int i = WIN_DEPTH - 1; i > 0; i--)
            scan_win[i] = scan_win[i - 1];
        scan_win[0] = d;
        if (scan_fill < WIN_DEPTH)
            scan_fill++;
        scan_seen++;
        if (!scan_done) begin
            len = pattern_span();
            k = len;
            for (int i = len - 1; i >= 0; i--)
                if (pattern_at(i) == 8'h00)
                    k = i;
            need = (k + DISP_BYTES > len) ? k + DISP_BYTES : len;
            if (scan_fill >= need && try_start_at(need - 1, len, k, POS_W'(need), r)) begin
                scan_done = 1'b1;
                hit = 1'b1;
            end
            if (last && !scan_done) begin
                // tail starts whose displacement runs past the region
                for (int o = need - 2; o >= len - 1 && !scan_done; o--)
                    if (o < scan_fill && try_start_at(o, len, k, POS_W'(o + 1), r)) begin
                        scan_done = 1'b1;
                        hit = 1'b1;
                    end
                if (!scan_done) begin
                    r = '0;
                    hit = 1'b1;
                end
            end
        end
        if (last)
            scan_clear();
        return hit;
    endfunction

    function automatic plan_row_t item_row(logic [7:0] d, bit last);
        plan_row_t row;
        row = '{ROW_ITEM, '0, '0, d, last, 1'b0, '0};
        return row;
    endfunction

    function automatic plan_row_t typed_row(logic [7:0] d, bit last, logic f,
                                            logic [POS_W-1:0] p, logic [BASE_W-1:0] q);
        plan_row_t row;
        row = '{ROW_ITEM, '0, '0, d, last, 1'b1, '{f, p, q}};
        return row;
    endfunction

    function automatic plan_row_t reg_row(logic [CFG_ADDR_W-1:0] a, logic [CFG_W-1:0] v);
        plan_row_t row;
        row = '{ROW_WRITE, a, v, 8'h00, 1'b0, 1'b0, '0};
        return row;
    endfunction

    task automatic write_reg(logic [CFG_ADDR_W-1:0] a, logic [CFG_W-1:0] v);
        cfg_we    <= 1'b1;
        cfg_addr  <= a;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (a)
            REG_PATTERN_LOW:    m_pat_lo  = v;
            REG_PATTERN_HIGH:   m_pat_hi  = v;
            REG_PATTERN_LENGTH: m_pat_len = v[LEN_W-1:0];
            REG_REGION_BASE:    m_base    = v[BASE_W-1:0];
            REG_POINTER_ADJUST: m_adj     = v[ADJ_W-1:0];
            default: ;
        endcase
        @(posedge clk);
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic send_item(logic [7:0] d, bit last, bit typed, scan_result_t want);
        int gap;
        scan_result_t r;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 25) : $urandom_range(0, 6);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 40);
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= d;
        s_tlast  <= last;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        live_items++;
        if (scan_byte(d, last, r) || typed)
            pending_results.push_back(typed ? want : r);
    endtask

    always @(posedge clk) begin : watch_results
        scan_result_t want;
        if (rst_n && m_tvalid && m_tready) begin
            if (pending_results.size() == 0) begin
                $display("%0t: result with none pending: found=%0b pos=%h ptr=%h",
                         $time, m_tuser, m_tdata[POS_W-1:0], m_tdata[POS_W +: BASE_W]);
                errors++;
            end else begin
                want = pending_results.pop_front();
                if (m_tuser !== want.found) begin
                    $display("%0t: found expected %0b actual %0b", $time, want.found, m_tuser);
                    errors++;
                end
                if (m_tdata[POS_W-1:0] !== want.pos) begin
                    $display("%0t: match_position expected %h actual %h",
                             $time, want.pos, m_tdata[POS_W-1:0]);
                    errors++;
                end
                if (m_tdata[POS_W +: BASE_W] !== want.ptr) begin
                    $display("%0t: resolved_pointer expected %h actual %h",
                             $time, want.ptr, m_tdata[POS_W +: BASE_W]);
                    errors++;
                end
            end
        end
    end

    initial begin : result_sink
        int mode;
        int seg;
        wait (rst_n);
        forever begin
            mode = $urandom_range(0, 3);
            seg  = $urandom_range(5, 60);
            repeat (seg) begin
                @(posedge clk);
                if (hold_req && !hold_done) begin
                    hold_done = 1'b1;
                    m_tready <= 1'b0;
                    repeat (LONG_HOLD) @(posedge clk);
                end else begin
                    case (mode)
                        0: m_tready <= 1'b1;
                        1: m_tready <= ($urandom_range(0, 99) < 70);
                        2: m_tready <= ~m_tready;
                        default: m_tready <= ($urandom_range(0, 99) < 20);
                    endcase
                end
            end
        end
    end

    initial begin : run_limit
        #(RUN_LIMIT_NS);
        $display("wildcard_signature_scan_rel32_core verification failed");
        $finish;
    end

    initial begin : stimulus
        logic [7:0]       pat [0:PAT_LIMIT-1];
        logic [7:0]       region [0:63];
        logic [CFG_W-1:0] lo;
        logic [CFG_W-1:0] hi;
        logic [CFG_W-1:0] v;
        int               zero_pct;
        int               len_code;
        int               span;
        int               style;
        int               n;
        int               p;
        int               idx;
        int               nreg;
        int               phase;

        scan_clear();
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: one wildcard byte, displacement at offset 0
        plan.push_back(typed_row(8'h7F, 1'b1, 1'b1, 32'd0, 48'h83));
        repeat (3) plan.push_back(item_row(8'hFF, 1'b0));
        plan.push_back(typed_row(8'hFF, 1'b1, 1'b1, 32'd0, 48'h3));
        // zero beyond the length is not a wildcard
        plan.push_back(reg_row(REG_PATTERN_LOW, 64'h0000_0000_0000_00AA));
        plan.push_back(typed_row(8'h00, 1'b1, 1'b0, 32'd0, 48'h0));
        plan.push_back(item_row(8'hAA, 1'b0));
        plan.push_back(item_row(8'h01, 1'b0));
        plan.push_back(item_row(8'h02, 1'b0));
        plan.push_back(item_row(8'h03, 1'b0));
        plan.push_back(item_row(8'h04, 1'b0));
        plan.push_back(item_row(8'h05, 1'b1));
        // length 0 acts as 1
        plan.push_back(reg_row(REG_PATTERN_LENGTH, 64'h0));
        plan.push_back(item_row(8'hAA, 1'b1));
        // length above the limit, full pattern, address wrap
        plan.push_back(reg_row(REG_PATTERN_LOW, 64'hFFFF_FFFF_FFFF_FFFF));
        plan.push_back(reg_row(REG_PATTERN_HIGH, 64'hFFFF_FFFF_FFFF_FFFF));
        plan.push_back(reg_row(REG_PATTERN_LENGTH, 64'h1F));
        plan.push_back(reg_row(REG_REGION_BASE, 64'h0000_FFFF_FFFF_FFFF));
        plan.push_back(reg_row(REG_POINTER_ADJUST, 64'hFFFF_FFFF_8000_0000));
        repeat (15) plan.push_back(item_row(8'hFF, 1'b0));
        plan.push_back(item_row(8'hFF, 1'b1));

        foreach (plan[i]) begin
            if (plan[i].kind == ROW_WRITE) begin
                wait_idle();
                write_reg(plan[i].addr, plan[i].value);
            end else begin
                send_item(plan[i].data, plan[i].last, plan[i].typed, plan[i].want);
            end
        end

        live_items = 0;
        phase = 0;
        while (live_items < RANDOM_ITEMS) begin
            wait_idle();
            case ($urandom_range(0, 4))
                0: zero_pct = 0;
                1: zero_pct = 100;
                2: zero_pct = 50;
                default: zero_pct = 15;
            endcase
            for (int i = 0; i < PAT_LIMIT; i++) begin
                if ($urandom_range(0, 99) < zero_pct)
                    pat[i] = 8'h00;
                else if ($urandom_range(0, 4) == 0)
                    pat[i] = 8'hFF;
                else
                    pat[i] = 8'($urandom_range(1, 255));
                lo = (i == 0) ? '0 : lo;
                hi = (i == 0) ? '0 : hi;
                if (i < 8)
                    lo[i * 8 +: 8] = pat[i];
                else
                    hi[(i - 8) * 8 +: 8] = pat[i];
            end
            write_reg(REG_PATTERN_LOW, lo);
            write_reg(REG_PATTERN_HIGH, hi);

            case ($urandom_range(0, 9))
                0: len_code = 0;
                1: len_code = $urandom_range(17, 31);
                2: len_code = PAT_LIMIT;
                default: len_code = $urandom_range(1, 6);
            endcase
            v = $urandom_range(0, 1) ? {$urandom, $urandom} : '0;
            v[LEN_W-1:0] = LEN_W'(len_code);
            write_reg(REG_PATTERN_LENGTH, v);

            case ($urandom_range(0, 4))
                0: v = 64'h0;
                1: v = 64'h0000_FFFF_FFFF_FFFF;
                default: v = {$urandom, $urandom};
            endcase
            write_reg(REG_REGION_BASE, v);

            v = {$urandom, $urandom};
            case ($urandom_range(0, 5))
                0: v[ADJ_W-1:0] = 32'h8000_0000;
                1: v[ADJ_W-1:0] = 32'h7FFF_FFFF;
                2: v[ADJ_W-1:0] = 32'h0;
                default: ;
            endcase
            write_reg(REG_POINTER_ADJUST, v);

            if ($urandom_range(0, 3) == 0)
                write_reg(CFG_ADDR_W'(REG_POINTER_ADJUST + 1 + $urandom_range(0, 2)),
                          {$urandom, $urandom});

            if (phase == 0)
                hold_req <= 1'b1;

            span = pattern_span();
            nreg = (phase == 0) ? 12 : $urandom_range(2, 6);
            repeat (nreg) begin
                style = $urandom_range(0, 9);
                n = (style <= 1) ? $urandom_range(1, 30) : $urandom_range(span, span + 24);
                for (int j = 0; j < n; j++)
                    region[j] = ($urandom_range(0, 2) == 0) ?
                                pat[$urandom_range(0, span - 1)] : 8'($urandom_range(0, 255));
                if (style >= 2) begin
                    if (style == 3) begin
                        p = n - span - $urandom_range(0, 3);
                        p = (p < 0) ? 0 : p;
                    end else begin
                        p = $urandom_range(0, n - span);
                    end
                    for (int j = 0; j < span; j++)
                        if (pat[j] != 8'h00)
                            region[p + j] = pat[j];
                    if (style == 2) begin
                        idx = $urandom_range(0, span - 1);
                        if (pat[idx] != 8'h00)
                            region[p + idx] = region[p + idx] ^ 8'($urandom_range(1, 255));
                    end
                end
                for (int j = 0; j < n; j++)
                    send_item(region[j], j == n - 1, 1'b0, '0);
            end
            phase++;
        end

        wait_idle();
        if (errors == 0)
            $display("wildcard_signature_scan_rel32_core verification clean");
        else
            $display("wildcard_signature_scan_rel32_core verification failed");
        $finish;
    end

endmodule

`default_nettype wire
